>>> sv/assert_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising edge outside reset.
`define FIR16_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising edge outside reset.
`define FIR16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/fir16_pkg.sv
// Types and constants of the 16-bit PCM FIR filter.
package fir16_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 16;
	localparam int MAX_TAPS = 7;
	localparam int TAP_W    = 3;

	// Coefficients enter the multiplier four bits at a time, low digit first.
	localparam int DIGIT_W     = 4;
	localparam int DIGITS      = COEF_W / DIGIT_W;
	localparam int DIGIT_IDX_W = 2;
	localparam int PP_W        = SAMPLE_W + DIGIT_W + 1;

	// Q2.14 products; seven of them need 34 bits plus sign headroom.
	localparam int FRAC_W = 14;
	localparam int ACC_W  = 35;
	localparam int Q_W    = ACC_W - FRAC_W;

	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(8192);
	localparam logic signed [ACC_W-1:0] NEG_BIAS   = ACC_W'(16383);

	// Register map
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;
	localparam logic [TAP_W-1:0] REG_TAP_COUNT = 3'd0;
	localparam logic [TAP_W-1:0] TAP_COUNT_RST = 3'd1;
	localparam logic [COEF_W-1:0] COEF0_RST    = 16'd16384;

	typedef struct packed {
		logic start;   // load the rounding offset into the accumulator
		logic step;    // add one coefficient digit times the sample
	} mac_ctrl_t;

endpackage

>>> sv/fir16_mac.sv
// Digit-serial multiply-accumulate with rounding and saturation to 16 bits.
module fir16_mac (
	input  logic                                 clk,
	input  fir16_pkg::mac_ctrl_t                 ctrl,
	input  logic signed [fir16_pkg::SAMPLE_W-1:0] sample,
	input  logic [fir16_pkg::DIGIT_W-1:0]         digit,
	input  logic [fir16_pkg::DIGIT_IDX_W-1:0]     digit_idx,
	output logic signed [fir16_pkg::SAMPLE_W-1:0] filtered,
	output logic                                 clipped
);

	logic signed [fir16_pkg::ACC_W-1:0]   acc_q;
	logic signed [fir16_pkg::DIGIT_W:0]   digit_s;
	logic signed [fir16_pkg::PP_W-1:0]    pp;
	logic signed [fir16_pkg::ACC_W-1:0]   pp_ext;
	logic signed [fir16_pkg::ACC_W-1:0]   pp_sh;
	logic [fir16_pkg::DIGIT_IDX_W+1:0]    shamt;
	logic signed [fir16_pkg::ACC_W-1:0]   rsum;
	logic signed [fir16_pkg::Q_W-1:0]     q;
	logic                                 top_digit;
	logic                                 in_range;

	// The top digit carries the sign weight of the coefficient.
	always_comb begin
		top_digit = (digit_idx == fir16_pkg::DIGIT_IDX_W'(fir16_pkg::DIGITS - 1));
		digit_s   = {top_digit & digit[fir16_pkg::DIGIT_W-1], digit};
		pp        = fir16_pkg::PP_W'(sample * digit_s);
		pp_ext    = {{(fir16_pkg::ACC_W - fir16_pkg::PP_W){pp[fir16_pkg::PP_W-1]}}, pp};
		shamt     = (fir16_pkg::DIGIT_IDX_W+2)'(digit_idx)
			* (fir16_pkg::DIGIT_IDX_W+2)'(fir16_pkg::DIGIT_W);
		pp_sh     = pp_ext <<< shamt;
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			acc_q <= fir16_pkg::ROUND_HALF;
		end else if (ctrl.step) begin
			acc_q <= acc_q + pp_sh;
		end
	end

	// Truncation toward zero: negative sums get the divisor less one added first.
	always_comb begin
		rsum     = acc_q + (acc_q[fir16_pkg::ACC_W-1] ? fir16_pkg::NEG_BIAS
			: fir16_pkg::ACC_W'(0));
		q        = rsum[fir16_pkg::ACC_W-1:fir16_pkg::FRAC_W];
		in_range = (&q[fir16_pkg::Q_W-1:fir16_pkg::SAMPLE_W-1])
			| ~(|q[fir16_pkg::Q_W-1:fir16_pkg::SAMPLE_W-1]);
		clipped  = ~in_range;
		if (in_range) begin
			filtered = q[fir16_pkg::SAMPLE_W-1:0];
		end else if (q[fir16_pkg::Q_W-1]) begin
			filtered = {1'b1, {(fir16_pkg::SAMPLE_W-1){1'b0}}};
		end else begin
			filtered = {1'b0, {(fir16_pkg::SAMPLE_W-1){1'b1}}};
		end
	end

endmodule

>>> sv/fir_filter_pcm16.sv
// Top level of the forward-looking FIR filter on signed 16-bit PCM words.
//
//  channel   direction  handshake                  contents
//  s_axis    in         tvalid/tready              tdata: sample_in; tlast: last_sample
//  m_axis    out        tvalid/tready              tdata: filtered; tuser: clipped;
//                                                  tlast: last_out
//  apb       in/out     psel/penable/pwrite/pready tap_count at 0x00, coef_0..6 at 0x04..0x1C
//
// Each result is worked out in steps: ST_CHECK decides, ST_MAC multiplies each tap that
// lands on a held sample one coefficient digit at a time and then sees that the taps are
// used up, and ST_ROUND rounds and loads the output register. A word that completes no
// result goes from the decision straight back to idle.
// A word is taken only while the filter is idle; a result waiting in the output
// register stalls the engine at its rounding step. Reset clears the window
// count, restores the tap count to one and coef_0 to unity gain.

`include "assert_macros.svh"

module fir_filter_pcm16 (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// Input stream
	input  logic                                    s_axis_tvalid,
	output logic                                    s_axis_tready,
	input  logic [15:0]                             s_axis_tdata,  // [15:0] sample_in
	input  logic                                    s_axis_tlast,
	// Output stream
	output logic                                    m_axis_tvalid,
	input  logic                                    m_axis_tready,
	output logic [15:0]                             m_axis_tdata,  // [15:0] filtered
	output logic                                    m_axis_tuser,  // [0] clipped
	output logic                                    m_axis_tlast,
	// Configuration
	input  logic                                    psel,
	input  logic                                    penable,
	input  logic                                    pwrite,
	input  logic [fir16_pkg::APB_ADDR_W-1:0]        paddr,
	input  logic [fir16_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [fir16_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                    pready
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_MAC   = 2'd2;
	localparam logic [1:0] ST_ROUND = 2'd3;

	logic [1:0]                                state_q;
	logic [fir16_pkg::TAP_W-1:0]               tap_q;
	logic [fir16_pkg::COEF_W-1:0]              coef_q [fir16_pkg::MAX_TAPS];
	logic [fir16_pkg::SAMPLE_W-1:0]            window_q [fir16_pkg::MAX_TAPS];
	logic [fir16_pkg::TAP_W-1:0]               fill_q;
	logic [fir16_pkg::TAP_W-1:0]               k_q;
	logic [fir16_pkg::DIGIT_IDX_W-1:0]         d_q;
	logic                                      last_q;

	logic                                      m_valid_q;
	logic [fir16_pkg::SAMPLE_W-1:0]            m_data_q;
	logic                                      m_user_q;
	logic                                      m_last_q;

	logic [fir16_pkg::TAP_W-1:0]               reg_idx;
	logic [fir16_pkg::TAP_W-1:0]               taps;
	logic [fir16_pkg::TAP_W-1:0]               slot;
	logic                                      cfg_wr;
	logic                                      in_acc;
	logic                                      go;
	logic                                      tap_ok;
	logic                                      out_free;
	logic                                      out_load;
	logic                                      out_last;
	fir16_pkg::mac_ctrl_t                      mac_ctrl;
	logic signed [fir16_pkg::SAMPLE_W-1:0]     mac_out;
	logic                                      mac_clip;

	// Register access. Every address of the port maps onto a register.
	assign reg_idx = paddr[fir16_pkg::APB_ADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign pready  = 1'b1;

	always_comb begin
		unique case (reg_idx)
			fir16_pkg::REG_TAP_COUNT: begin
				prdata = fir16_pkg::APB_DATA_W'(tap_q);
			end
			default: begin
				prdata = {{(fir16_pkg::APB_DATA_W - fir16_pkg::COEF_W)
					{coef_q[reg_idx - 3'd1][fir16_pkg::COEF_W-1]}},
					coef_q[reg_idx - 3'd1]};
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= fir16_pkg::TAP_COUNT_RST;
			for (int i = 0; i < fir16_pkg::MAX_TAPS; i++) begin
				coef_q[i] <= '0;
			end
			coef_q[0] <= fir16_pkg::COEF0_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				fir16_pkg::REG_TAP_COUNT: begin
					tap_q <= pwdata[fir16_pkg::TAP_W-1:0];
				end
				default: begin
					coef_q[reg_idx - 3'd1] <= pwdata[fir16_pkg::COEF_W-1:0];
				end
			endcase
		end
	end

	// A tap count of zero behaves as one; seven is already the ceiling.
	assign taps = (tap_q == '0) ? fir16_pkg::TAP_W'(1) : tap_q;

	// The new sample lands just past the held ones.
	assign slot = (fill_q > fir16_pkg::TAP_W'(fir16_pkg::MAX_TAPS - 1))
		? fir16_pkg::TAP_W'(fir16_pkg::MAX_TAPS - 1) : fill_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid & s_axis_tready;

	// On the last word every held sample yields a result; otherwise only a full window.
	assign go       = last_q ? (fill_q != '0) : (fill_q >= taps);
	assign tap_ok   = (k_q < taps) && (k_q < fill_q);
	assign out_free = ~m_valid_q | m_axis_tready;
	assign out_load = (state_q == ST_ROUND) & out_free;
	assign out_last = last_q & (fill_q == fir16_pkg::TAP_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			k_q     <= '0;
			d_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						fill_q  <= slot + fir16_pkg::TAP_W'(1);
						last_q  <= s_axis_tlast;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					k_q <= '0;
					d_q <= '0;
					if (go) begin
						state_q <= ST_MAC;
					end else begin
						last_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_MAC: begin
					if (tap_ok) begin
						d_q <= d_q + fir16_pkg::DIGIT_IDX_W'(1);
						if (d_q == fir16_pkg::DIGIT_IDX_W'(fir16_pkg::DIGITS - 1)) begin
							k_q <= k_q + fir16_pkg::TAP_W'(1);
						end
					end else begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					// Each result retires the oldest held sample.
					if (out_free) begin
						fill_q  <= fill_q - fir16_pkg::TAP_W'(1);
						state_q <= ST_CHECK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sample window, oldest first; a retired sample shifts everything down by one.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			window_q[slot] <= s_axis_tdata;
		end else if (out_load) begin
			for (int i = 0; i < fir16_pkg::MAX_TAPS - 1; i++) begin
				window_q[i] <= window_q[i+1];
			end
			window_q[fir16_pkg::MAX_TAPS-1] <= '0;
		end
	end

	always_comb begin
		mac_ctrl.start = (state_q == ST_CHECK) & go;
		mac_ctrl.step  = (state_q == ST_MAC) & tap_ok;
	end

	fir16_mac u_mac (
		.clk       (clk),
		.ctrl      (mac_ctrl),
		.sample    (window_q[k_q]),
		.digit     (coef_q[k_q][d_q * fir16_pkg::DIGIT_W +: fir16_pkg::DIGIT_W]),
		.digit_idx (d_q),
		.filtered  (mac_out),
		.clipped   (mac_clip)
	);

	// Output register: holds one result until the sink takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= mac_out;
			m_user_q <= mac_clip;
			m_last_q <= out_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;
	assign m_axis_tlast  = m_last_q;

	// The final result of a stream leaves the window empty.
	`FIR16_ASSERT_NEXT(a_last_empties, clk, arst_n, out_load && out_last, fill_q == '0, "window not empty after final result")
	// The multiplier only runs over held samples.
	`FIR16_ASSERT_SAME(a_mac_has_data, clk, arst_n, state_q == ST_MAC, (fill_q != '0) && (k_q <= fill_q), "multiply beyond held samples")
	// Between words at most six samples wait for the next one.
	`FIR16_ASSERT_SAME(a_idle_fill, clk, arst_n, state_q == ST_IDLE, fill_q <= fir16_pkg::TAP_W'(fir16_pkg::MAX_TAPS - 1), "window overfull while idle")

endmodule
